// File: rtl/afrf_pkg.sv
// shared types and constants for the aligned free range finder
package afrf_pkg;

   localparam int MemoryEntriesDefault    = 8;
   localparam int ReservedEntriesDefault  = 16;
   localparam int ProtectedEntriesDefault = 8;

   localparam int AddrWidth = 64;

   typedef enum logic [2:0] {
      OP_ADD_MEMORY    = 3'd0,
      OP_ADD_RESERVED  = 3'd1,
      OP_ADD_PROTECTED = 3'd2,
      OP_REQUEST       = 3'd3,
      OP_CLEAR         = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_INVALID   = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch request and start
      logic mem_rd;     // read memory entry at mem index
      logic mem_setup;  // evaluate memory entry, align base
      logic blk_rd;     // read blocker entry at blk index
      logic blk_test;   // compare blocker with candidate
      logic skip;       // move cursor to blocker end aligned
      logic next_mem;   // advance memory index
      logic next_blk;   // advance blocker index
      logic blk_clr;    // restart blocker scan
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_bad;
      logic mem_done;   // no more memory entries
      logic mem_skip;   // entry invalid or align overflow
      logic cand_fail;  // cursor past end or size does not fit
      logic blk_done;   // no more blocker entries
      logic hit;        // blocker overlaps candidate
      logic skip_ovf;   // blocker end realign overflows
      logic skip_bad;   // blocker ends at or before cursor
   } sts_type;

endpackage

// File: rtl/afrf_datapath.sv
// datapath: range tables, cursor and compare logic
module afrf_datapath #(
   parameter int MEMORY_ENTRIES    = afrf_pkg::MemoryEntriesDefault,
   parameter int RESERVED_ENTRIES  = afrf_pkg::ReservedEntriesDefault,
   parameter int PROTECTED_ENTRIES = afrf_pkg::ProtectedEntriesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  afrf_pkg::op_type      wr_op,
   input  logic [63:0]           wr_base,
   input  logic [63:0]           wr_length,
   input  logic [63:0]           rq_bytes,
   input  logic [63:0]           rq_align,
   input  afrf_pkg::cmd_type     cmd,
   output afrf_pkg::sts_type     sts,
   output logic [63:0]           cur_base,
   output logic [63:0]           cur_bytes
);
   import afrf_pkg::*;

   localparam int MW = $clog2(MEMORY_ENTRIES + 1);
   localparam int RW = $clog2(RESERVED_ENTRIES + 1);
   localparam int PW = $clog2(PROTECTED_ENTRIES + 1);
   localparam int MI = (MEMORY_ENTRIES > 1) ? $clog2(MEMORY_ENTRIES) : 1;
   localparam int RI = (RESERVED_ENTRIES > 1) ? $clog2(RESERVED_ENTRIES) : 1;
   localparam int PI = (PROTECTED_ENTRIES > 1) ? $clog2(PROTECTED_ENTRIES) : 1;
   localparam int BW = ((RW > PW) ? RW : PW) + 1;

   logic [127:0] mem_tab [MEMORY_ENTRIES];
   logic [127:0] res_tab [RESERVED_ENTRIES];
   logic [127:0] pro_tab [PROTECTED_ENTRIES];

   logic [MW-1:0] mem_used_ff, mem_used_in;
   logic [RW-1:0] res_used_ff, res_used_in;
   logic [PW-1:0] pro_used_ff, pro_used_in;

   logic [MW-1:0] mem_idx_ff;
   logic [BW-1:0] blk_idx_ff;
   logic [63:0]   bytes_ff, mask_ff, cur_ff, end_ff, bb_ff, bl_ff;
   logic [127:0]  mem_rd_ff, res_rd_ff, pro_rd_ff;
   logic          bad_ff, blk_pro_ff;

   always_comb begin
      mem_used_in = mem_used_ff;
      res_used_in = res_used_ff;
      pro_used_in = pro_used_ff;
      if (wr_en) begin
         unique case (wr_op)
            OP_ADD_MEMORY:
               if (mem_used_ff < MW'(MEMORY_ENTRIES)) mem_used_in = mem_used_ff + 1'b1;
            OP_ADD_RESERVED:
               if (res_used_ff < RW'(RESERVED_ENTRIES)) res_used_in = res_used_ff + 1'b1;
            OP_ADD_PROTECTED:
               if (pro_used_ff < PW'(PROTECTED_ENTRIES)) pro_used_in = pro_used_ff + 1'b1;
            OP_CLEAR: begin
               mem_used_in = '0;
               res_used_in = '0;
               pro_used_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_used_ff <= '0;
         res_used_ff <= '0;
         pro_used_ff <= '0;
      end else begin
         mem_used_ff <= mem_used_in;
         res_used_ff <= res_used_in;
         pro_used_ff <= pro_used_in;
      end
   end

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (wr_en && wr_op == OP_ADD_MEMORY && mem_used_ff < MW'(MEMORY_ENTRIES))
         mem_tab[mem_used_ff[MI-1:0]] <= {wr_length, wr_base};
      if (wr_en && wr_op == OP_ADD_RESERVED && res_used_ff < RW'(RESERVED_ENTRIES))
         res_tab[res_used_ff[RI-1:0]] <= {wr_length, wr_base};
      if (wr_en && wr_op == OP_ADD_PROTECTED && pro_used_ff < PW'(PROTECTED_ENTRIES))
         pro_tab[pro_used_ff[PI-1:0]] <= {wr_length, wr_base};
      if (cmd.mem_rd) mem_rd_ff <= mem_tab[mem_idx_ff[MI-1:0]];
      if (cmd.blk_rd) begin
         res_rd_ff <= res_tab[blk_idx_ff[RI-1:0]];
         pro_rd_ff <= pro_tab[PI'(blk_idx_ff - BW'(res_used_ff))];
         blk_pro_ff <= blk_idx_ff >= BW'(res_used_ff);
      end
   end

   logic [63:0] mb, ml, eb, el, cand_end;
   logic [64:0] mem_sum, mem_al, blk_end, blk_al, c_end;
   logic        mem_ok, blk_ok;

   always_comb begin
      mb = mem_rd_ff[63:0];
      ml = mem_rd_ff[127:64];
      mem_sum = {1'b0, mb} + {1'b0, ml};
      mem_ok = (ml != '0) && !mem_sum[64];
      mem_al = {1'b0, mb} + {1'b0, mask_ff};
      eb = blk_pro_ff ? pro_rd_ff[63:0] : res_rd_ff[63:0];
      el = blk_pro_ff ? pro_rd_ff[127:64] : res_rd_ff[127:64];
      blk_end = {1'b0, eb} + {1'b0, el};
      blk_ok = (el != '0) && !blk_end[64];
      c_end = {1'b0, cur_ff} + {1'b0, bytes_ff};
      cand_end = c_end[63:0];
      blk_al = {1'b0, bb_ff} + {1'b0, bl_ff} + {1'b0, mask_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bytes_ff <= rq_bytes;
         mask_ff <= rq_align - 64'd1;
         bad_ff <= (rq_bytes == '0) || (rq_align == '0) ||
                   ((rq_align & (rq_align - 64'd1)) != '0);
      end
      if (reset || cmd.load) mem_idx_ff <= '0;
      else if (cmd.next_mem) mem_idx_ff <= mem_idx_ff + 1'b1;
      if (reset || cmd.blk_clr) blk_idx_ff <= '0;
      else if (cmd.next_blk) blk_idx_ff <= blk_idx_ff + 1'b1;
      if (cmd.mem_setup) begin
         end_ff <= mem_sum[63:0];
         cur_ff <= mem_al[63:0] & ~mask_ff;
      end
      if (cmd.blk_test) begin
         bb_ff <= eb;
         bl_ff <= el;
      end
      if (cmd.skip) cur_ff <= blk_al[63:0] & ~mask_ff;
   end

   always_comb begin
      sts.req_bad   = bad_ff;
      sts.mem_done  = mem_idx_ff >= mem_used_ff;
      sts.mem_skip  = !mem_ok || mem_al[64];
      sts.cand_fail = (cur_ff >= end_ff) || (bytes_ff > end_ff - cur_ff);
      sts.blk_done  = blk_idx_ff >= BW'(res_used_ff) + BW'(pro_used_ff);
      // candidate is valid here since it fits inside a valid memory range
      sts.hit       = blk_ok && (cur_ff < blk_end[63:0]) && (eb < cand_end);
      sts.skip_ovf  = blk_al[64];
      sts.skip_bad  = ({1'b0, bb_ff} + {1'b0, bl_ff}) <= {1'b0, cur_ff};
   end

   assign cur_base  = cur_ff;
   assign cur_bytes = bytes_ff;

endmodule

// File: rtl/afrf_ctrl.sv
// controller: sequences the first-fit scan
module afrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  afrf_pkg::sts_type      sts,
   output afrf_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   done,
   output afrf_pkg::status_type   result
);
   import afrf_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CHECK = 9'b000000010,
      S_MRD   = 9'b000000100,
      S_MSET  = 9'b000001000,
      S_CAND  = 9'b000010000,
      S_BRD   = 9'b000100000,
      S_BTEST = 9'b001000000,
      S_SKIP  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   status_type result_ff, result_in;

   always_comb begin
      state_in = state_ff;
      result_in = result_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: priority if (sts.req_bad) begin
            result_in = ST_INVALID;
            state_in = S_DONE;
         end else if (sts.mem_done) begin
            result_in = ST_EXHAUSTED;
            state_in = S_DONE;
         end else begin
            state_in = S_MRD;
         end
         S_MRD: state_in = S_MSET;
         S_MSET: begin
            cmd.next_mem = 1'b1;
            if (sts.mem_skip) state_in = S_CHECK;
            else begin
               cmd.mem_setup = 1'b1;
               state_in = S_CAND;
            end
         end
         S_CAND: begin
            cmd.blk_clr = 1'b1;
            if (sts.cand_fail) state_in = S_CHECK;
            else state_in = S_BRD;
         end
         S_BRD: priority if (sts.blk_done) begin
            result_in = ST_FOUND;
            state_in = S_DONE;
         end else begin
            state_in = S_BTEST;
         end
         S_BTEST: begin
            if (sts.hit) begin
               cmd.blk_test = 1'b1;
               state_in = S_SKIP;
            end else begin
               cmd.next_blk = 1'b1;
               state_in = S_BRD;
            end
         end
         S_SKIP: priority if (sts.skip_bad) begin
            result_in = ST_INVALID;
            state_in = S_DONE;
         end else if (sts.skip_ovf) begin
            state_in = S_CHECK;
         end else begin
            cmd.skip = 1'b1;
            state_in = S_CAND;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      cmd.mem_rd = (state_ff == S_MRD);
      cmd.blk_rd = (state_ff == S_BRD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         result_ff <= ST_FOUND;
      end else begin
         state_ff <= state_in;
         result_ff <= result_in;
      end
   end

   assign busy   = state_ff != S_IDLE;
   assign done   = state_ff == S_DONE;
   assign result = result_ff;

endmodule

// File: rtl/aligned_free_range_finder.sv
// top level of the aligned free range finder
// loads and clears update the tables when accepted; a request scans memory
// entries in order, each candidate position tested against every reserved and
// protected entry in turn; requests are handled one at a time, as req_tready
// stays low while a scan runs or a response waits to be taken
// synchronous active-high reset empties all tables; entry storage is not reset
module aligned_free_range_finder #(
   parameter int MEMORY_ENTRIES    = afrf_pkg::MemoryEntriesDefault,
   parameter int RESERVED_ENTRIES  = afrf_pkg::ReservedEntriesDefault,
   parameter int PROTECTED_ENTRIES = afrf_pkg::ProtectedEntriesDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // op[2:0], entry_base[66:3], entry_length[130:67], request_bytes[194:131],
   // request_alignment[258:195]
   input  logic [263:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], found_base[65:2], found_length[129:66]
   output logic [135:0]  rsp_tdata
);
   import afrf_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   status_type result;
   logic       busy, done, start, wr_en;
   logic [63:0] cur_base, cur_bytes;
   logic        rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   op_type     op;

   assign op = op_type'(req_tdata[2:0]);
   assign req_tready = !busy && !rsp_valid_ff;
   assign wr_en = req_tvalid && req_tready;
   assign start = wr_en && op == OP_REQUEST;

   afrf_ctrl u_ctrl (
      .clock, .reset, .start, .sts, .cmd, .busy, .done, .result
   );

   afrf_datapath #(
      .MEMORY_ENTRIES(MEMORY_ENTRIES),
      .RESERVED_ENTRIES(RESERVED_ENTRIES),
      .PROTECTED_ENTRIES(PROTECTED_ENTRIES)
   ) u_dp (
      .clock, .reset, .wr_en, .wr_op(op),
      .wr_base(req_tdata[66:3]), .wr_length(req_tdata[130:67]),
      .rq_bytes(req_tdata[194:131]), .rq_align(req_tdata[258:195]),
      .cmd, .sts, .cur_base, .cur_bytes
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (done)
         rsp_data_ff <= {6'd0,
                         (result == ST_FOUND) ? cur_bytes : 64'd0,
                         (result == ST_FOUND) ? cur_base : 64'd0,
                         result};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("input taken while scanning");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result lost");
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_FOUND) |-> rsp_tdata[129:2] == '0)
      else $error("nonzero payload without found");

endmodule
